// ===== sv/rtp_raw_video_packetizer_macros.svh =====
// Assertion macros for the RTP raw video packetizer.
// Used by rtp_raw_video_packetizer.sv; expects clk and rst_n in scope.
`ifndef RTP_RAW_VIDEO_PACKETIZER_MACROS_SVH
`define RTP_RAW_VIDEO_PACKETIZER_MACROS_SVH

// same-cycle implication
`define RVP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RVP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rvp_pkg.sv =====
// Package for the RTP raw video packetizer: frame geometry, header sizes,
// register and action codes. No dependencies.
package rvp_pkg;

    localparam int FRAME_WIDTH  = 20;
    localparam int FRAME_HEIGHT = 10;

    localparam int HDR_BYTES  = 14 + 6 * FRAME_HEIGHT;
    localparam int HDR_WORDS  = (HDR_BYTES + 7) / 8;
    localparam int LAST_COUNT = HDR_BYTES - 8 * (HDR_WORDS - 1);
    localparam int PIX_TOTAL  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int PIX_W      = $clog2(PIX_TOTAL + 1);
    localparam int WORD_W     = $clog2(HDR_WORDS);
    localparam int ROW_W      = $clog2(FRAME_HEIGHT + 3);
    localparam int ROW_LEN    = FRAME_WIDTH * 3;
    localparam int PIX_BYTES  = 3;

    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0] MARKER_BIT       = 8'h80;
    localparam logic [7:0] CONT_BIT         = 8'h80;

    localparam logic [7:0] BRIGHTNESS_RESET = 8'd128;
    localparam logic [6:0] PAYLOAD_RESET    = 7'd96;

    typedef enum logic [1:0] {
        REG_BRIGHTNESS = 2'd0,
        REG_SSRC       = 2'd1,
        REG_PAYLOAD    = 2'd2
    } reg_idx_t;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_PIXEL = 1'b1
    } action_t;

endpackage

// ===== sv/rtp_raw_video_packetizer.sv =====
// RTP/RFC4175 raw video packetizer: input register, header byte generation,
// pixel scaling and result register. Depends on rvp_pkg and the macros header.
//
// Pixel items are taken one per clock while the output is not stalled, and each
// gives one 3-byte beat through the input register and the result register. A
// start item holds the input while its HDR_WORDS header words (10 at the default
// 20x10 frame) go out, one per cycle that the output is not stalled. Pixels outside
// a frame are dropped from the input register without a beat. No clearing pass after reset.
`include "rtp_raw_video_packetizer_macros.svh"

module rtp_raw_video_packetizer
    import rvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [31:0] time_stamp,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] packet_bytes,
    output logic [3:0]  byte_count,
    output logic        end_of_packet
);

    logic [7:0]  brightness_reg;
    logic [31:0] ssrc_reg;
    logic [6:0]  payload_reg;

    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [31:0] s1_ts_reg;
    logic [7:0]  s1_red_reg;
    logic [7:0]  s1_green_reg;
    logic [7:0]  s1_blue_reg;

    logic [WORD_W-1:0] hdr_word_reg, hdr_word_next;
    logic [ROW_W-1:0]  row1_reg, row1_next;
    logic [2:0]        pos_reg, pos_next;

    logic [31:0]      seq_reg;
    logic [PIX_W-1:0] pixels_sent_reg;
    logic             frame_open_reg;

    logic        out_valid_reg;
    logic [63:0] out_bytes_reg;
    logic [3:0]  out_count_reg;
    logic        out_eop_reg;

    logic cfg_write;
    logic out_free;
    logic is_start;
    logic pix_live;
    logic pix_drop;
    logic hdr_last;
    logic emit;
    logic s1_pop;
    logic in_take;

    logic [PIX_W-1:0] pix_inc;
    logic             pix_end;
    logic [63:0]      hdr_word_bytes;
    logic [63:0]      pix_word_bytes;
    logic [15:0]      row_len16;

    function automatic logic [7:0] scale_byte(input logic [7:0] v, input logic [7:0] g);
        logic [15:0] prod;
        logic [16:0] sum;
        prod = 16'(v) * 16'(g);
        sum  = {1'b0, prod} + 17'(prod[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

    // APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BRIGHTNESS: prdata = {24'd0, brightness_reg};
            REG_SSRC:       prdata = ssrc_reg;
            REG_PAYLOAD:    prdata = {25'd0, payload_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // flow control
    assign out_free = !out_valid_reg || !out_stall;
    assign is_start = s1_valid_reg && (s1_action_reg == ACT_START);
    assign pix_live = s1_valid_reg && (s1_action_reg == ACT_PIXEL) && frame_open_reg;
    assign pix_drop = s1_valid_reg && (s1_action_reg == ACT_PIXEL) && !frame_open_reg;
    assign hdr_last = hdr_word_reg == WORD_W'(HDR_WORDS - 1);
    assign emit     = out_free && (is_start || pix_live);
    assign s1_pop   = pix_drop || (out_free && (pix_live || (is_start && hdr_last)));
    assign in_stall = s1_valid_reg && !s1_pop;
    assign in_take  = in_valid && !in_stall;

    assign pix_inc = pixels_sent_reg + PIX_W'(1);
    assign pix_end = pix_inc >= PIX_W'(PIX_TOTAL);

    assign pix_word_bytes = {scale_byte(s1_red_reg, brightness_reg),
                             scale_byte(s1_green_reg, brightness_reg),
                             scale_byte(s1_blue_reg, brightness_reg), 40'd0};

    assign row_len16 = 16'(ROW_LEN);

    // header word: row1 is the line header number plus one, row1 of zero
    // stands for the tail of the fixed header
    always_comb
    begin
        logic [3:0]       p;
        logic [1:0]       adj;
        logic [2:0]       pp;
        logic [ROW_W-1:0] r1;
        logic [15:0]      row16;
        logic [7:0]       b;
        hdr_word_bytes = 64'd0;
        for (int k = 0; k < 8; k++)
        begin
            p = {1'b0, pos_reg} + 4'(k);
            if (p >= 4'd12)
                adj = 2'd2;
            else if (p >= 4'd6)
                adj = 2'd1;
            else
                adj = 2'd0;
            pp    = 3'(p - 4'(adj) * 4'd6);
            r1    = row1_reg + ROW_W'(adj);
            row16 = 16'(r1 - ROW_W'(1));
            b     = 8'd0;
            if (hdr_word_reg == '0)
            begin
                case (k)
                    0:       b = RTP_VERSION_BYTE;
                    1:       b = MARKER_BIT | {1'b0, payload_reg};
                    2:       b = seq_reg[15:8];
                    3:       b = seq_reg[7:0];
                    4:       b = s1_ts_reg[31:24];
                    5:       b = s1_ts_reg[23:16];
                    6:       b = s1_ts_reg[15:8];
                    default: b = s1_ts_reg[7:0];
                endcase
            end
            else if (r1 == '0)
            begin
                case (pp)
                    3'd0:    b = ssrc_reg[31:24];
                    3'd1:    b = ssrc_reg[23:16];
                    3'd2:    b = ssrc_reg[15:8];
                    3'd3:    b = ssrc_reg[7:0];
                    3'd4:    b = seq_reg[31:24];
                    3'd5:    b = seq_reg[23:16];
                    default: b = 8'd0;
                endcase
            end
            else if (r1 <= ROW_W'(FRAME_HEIGHT))
            begin
                case (pp)
                    3'd0:    b = row_len16[15:8];
                    3'd1:    b = row_len16[7:0];
                    3'd2:    b = row16[15:8];
                    3'd3:    b = row16[7:0];
                    3'd4:    b = (r1 != ROW_W'(FRAME_HEIGHT)) ? CONT_BIT : 8'd0;
                    default: b = 8'd0;
                endcase
            end
            hdr_word_bytes[63 - 8*k -: 8] = b;
        end
    end

    // header walk
    always_comb
    begin
        hdr_word_next = hdr_word_reg;
        row1_next     = row1_reg;
        pos_next      = pos_reg;
        if (is_start && out_free)
        begin
            if (hdr_last)
            begin
                hdr_word_next = '0;
                row1_next     = '0;
                pos_next      = '0;
            end
            else
            begin
                hdr_word_next = hdr_word_reg + WORD_W'(1);
                if (hdr_word_reg != '0)
                begin
                    if (pos_reg >= 3'd4)
                    begin
                        pos_next  = pos_reg - 3'd4;
                        row1_next = row1_reg + ROW_W'(2);
                    end
                    else
                    begin
                        pos_next  = pos_reg + 3'd2;
                        row1_next = row1_reg + ROW_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg  <= BRIGHTNESS_RESET;
            ssrc_reg        <= 32'd0;
            payload_reg     <= PAYLOAD_RESET;
            s1_valid_reg    <= 1'b0;
            hdr_word_reg    <= '0;
            row1_reg        <= '0;
            pos_reg         <= '0;
            seq_reg         <= 32'd0;
            pixels_sent_reg <= '0;
            frame_open_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (paddr[3:2])
                    REG_BRIGHTNESS: brightness_reg <= pwdata[7:0];
                    REG_SSRC:       ssrc_reg       <= pwdata;
                    REG_PAYLOAD:    payload_reg    <= pwdata[6:0];
                    default:        ;
                endcase
            end

            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_pop)
                s1_valid_reg <= 1'b0;

            hdr_word_reg <= hdr_word_next;
            row1_reg     <= row1_next;
            pos_reg      <= pos_next;

            if (is_start && out_free && hdr_last)
            begin
                seq_reg         <= seq_reg + 32'd1;
                pixels_sent_reg <= '0;
                frame_open_reg  <= 1'b1;
            end
            else if (pix_live && out_free)
            begin
                if (pix_end)
                begin
                    pixels_sent_reg <= '0;
                    frame_open_reg  <= 1'b0;
                end
                else
                begin
                    pixels_sent_reg <= pix_inc;
                end
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_action_reg <= action;
            s1_ts_reg     <= time_stamp;
            s1_red_reg    <= red;
            s1_green_reg  <= green;
            s1_blue_reg   <= blue;
        end
        if (emit)
        begin
            if (is_start)
            begin
                out_bytes_reg <= hdr_word_bytes;
                out_count_reg <= hdr_last ? 4'(LAST_COUNT) : 4'd8;
                out_eop_reg   <= 1'b0;
            end
            else
            begin
                out_bytes_reg <= pix_word_bytes;
                out_count_reg <= 4'(PIX_BYTES);
                out_eop_reg   <= pix_end;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign packet_bytes  = out_bytes_reg;
    assign byte_count    = out_count_reg;
    assign end_of_packet = out_eop_reg;

    `RVP_ASSERT_NOW(a_hdr_keeps_output, is_start && (hdr_word_reg != '0), out_valid_reg,
        "header word pending without an earlier word in the output")
    `RVP_ASSERT_NOW(a_drop_no_stall, pix_drop, !in_stall,
        "dropped pixel held the input")
    `RVP_ASSERT_NOW(a_closed_frame_count, !frame_open_reg, pixels_sent_reg == '0,
        "pixel count nonzero with no frame open")
    `RVP_ASSERT_NOW(a_eop_pixel_beat, out_valid_reg && out_eop_reg,
        out_count_reg == 4'(PIX_BYTES), "end of packet on a non-pixel beat")
    `RVP_ASSERT_NEXT(a_last_hdr_opens, is_start && out_free && hdr_last, frame_open_reg,
        "frame not open after the last header word")

endmodule

// ===== sim/rvp_checker.sv =====
// Checker for the RTP raw video packetizer: snoops register writes and both
// beat channels, predicts every output beat and compares. Depends on rvp_pkg.
`timescale 1ns / 100ps

module rvp_checker
    import rvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        action,
    input  logic [31:0] time_stamp,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] packet_bytes,
    input  logic [3:0]  byte_count,
    input  logic        end_of_packet,

    output int          error_count,
    output int          beats_due
);

    typedef struct {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        eop;
    } beat_t;

    beat_t pending_beats[$];
    beat_t want;

    logic [7:0]       gain;
    logic [31:0]      ssrc;
    logic [6:0]       ptype;
    logic [31:0]      seq_count;
    logic [PIX_W-1:0] pix_sent;
    logic             frame_live;
    int               mismatches;

    function automatic logic [7:0] scale_color(input logic [7:0] v);
        logic [15:0] prod;
        begin
            prod = 16'(v) * 16'(gain);
            return 8'(prod / 16'd255);
        end
    endfunction

    task automatic predict_item(input logic act, input logic [31:0] ts,
                                input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b);
        logic [7:0]  hdr [0:HDR_WORDS*8-1];
        logic [15:0] row_len;
        logic [15:0] row;
        logic [63:0] word;
        beat_t       nb;
        int          n;
        int          left;
        begin
            if (act == ACT_START) begin
                for (int i = 0; i < HDR_WORDS * 8; i++)
                    hdr[i] = 8'h00;
                row_len = 16'(ROW_LEN);
                hdr[0]  = RTP_VERSION_BYTE;
                hdr[1]  = MARKER_BIT | {1'b0, ptype};
                hdr[2]  = seq_count[15:8];
                hdr[3]  = seq_count[7:0];
                hdr[4]  = ts[31:24];
                hdr[5]  = ts[23:16];
                hdr[6]  = ts[15:8];
                hdr[7]  = ts[7:0];
                hdr[8]  = ssrc[31:24];
                hdr[9]  = ssrc[23:16];
                hdr[10] = ssrc[15:8];
                hdr[11] = ssrc[7:0];
                hdr[12] = seq_count[31:24];
                hdr[13] = seq_count[23:16];
                n = 14;
                for (int y = 0; y < FRAME_HEIGHT; y++) begin
                    row = 16'(y);
                    hdr[n]   = row_len[15:8];
                    hdr[n+1] = row_len[7:0];
                    hdr[n+2] = row[15:8];
                    hdr[n+3] = row[7:0];
                    hdr[n+4] = (y != FRAME_HEIGHT - 1) ? CONT_BIT : 8'h00;
                    hdr[n+5] = 8'h00;
                    n += 6;
                end
                for (int w = 0; w < HDR_WORDS; w++) begin
                    word = 64'd0;
                    for (int k = 0; k < 8; k++)
                        word = {word[55:0], hdr[8*w+k]};
                    left = HDR_BYTES - 8 * w;
                    nb.bytes = word;
                    nb.count = (left > 8) ? 4'd8 : 4'(left);
                    nb.eop   = 1'b0;
                    pending_beats.push_back(nb);
                end
                seq_count  = seq_count + 32'd1;
                pix_sent   = '0;
                frame_live = 1'b1;
            end else if (frame_live) begin
                nb.bytes = {scale_color(r), scale_color(g), scale_color(b), 40'd0};
                nb.count = 4'(PIX_BYTES);
                pix_sent = pix_sent + 1'b1;
                if (pix_sent >= PIX_W'(PIX_TOTAL)) begin
                    nb.eop     = 1'b1;
                    pix_sent   = '0;
                    frame_live = 1'b0;
                end else begin
                    nb.eop = 1'b0;
                end
                pending_beats.push_back(nb);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_beats.delete();
            gain        = BRIGHTNESS_RESET;
            ssrc        = 32'd0;
            ptype       = PAYLOAD_RESET;
            seq_count   = 32'd0;
            pix_sent    = '0;
            frame_live  = 1'b0;
            mismatches  = 0;
            error_count <= 0;
            beats_due   <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_BRIGHTNESS: gain  = pwdata[7:0];
                    REG_SSRC:       ssrc  = pwdata;
                    REG_PAYLOAD:    ptype = pwdata[6:0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (pending_beats.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected beat: bytes %h count %0d eop %b",
                                 packet_bytes, byte_count, end_of_packet);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = pending_beats.pop_front();
                    if (packet_bytes !== want.bytes || byte_count !== want.count ||
                        end_of_packet !== want.eop)
                    begin
                        if (mismatches < 10)
                            $display({"beat mismatch: expected bytes %h count %0d eop %b,",
                                      " got bytes %h count %0d eop %b"},
                                     want.bytes, want.count, want.eop,
                                     packet_bytes, byte_count, end_of_packet);
                        mismatches = mismatches + 1;
                    end
                end
            end

            if (in_valid && !in_stall)
                predict_item(action, time_stamp, red, green, blue);

            error_count <= mismatches;
            beats_due   <= pending_beats.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// Top of the packetizer testbench: clock, reset, register writes, beat stimulus
// and the verdict. Depends on rvp_pkg, rvp_checker and the packetizer RTL.
`timescale 1ns / 100ps

module tb
    import rvp_pkg::*;
();

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = 1'b0;
    logic [31:0] time_stamp = 32'd0;
    logic [7:0]  red = 8'd0;
    logic [7:0]  green = 8'd0;
    logic [7:0]  blue = 8'd0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] packet_bytes;
    logic [3:0]  byte_count;
    logic        end_of_packet;

    int          error_count;
    int          beats_due;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    rtp_raw_video_packetizer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .time_stamp    (time_stamp),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .packet_bytes  (packet_bytes),
        .byte_count    (byte_count),
        .end_of_packet (end_of_packet)
    );

    rvp_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .time_stamp    (time_stamp),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .packet_bytes  (packet_bytes),
        .byte_count    (byte_count),
        .end_of_packet (end_of_packet),
        .error_count   (error_count),
        .beats_due     (beats_due)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0] pick_color();
        int r;
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                return 8'h00;
            else if (r == 1)
                return 8'hFF;
            return 8'($urandom_range(0, 255));
        end
    endfunction

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= val;
            @(posedge clk);
            penable <= 1'b1;
            @(negedge clk);
            while (!pready)
                @(negedge clk);
            @(posedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
    endtask

    // one beat into the block, with a random gap in front
    task automatic send_item(input logic act, input logic [31:0] ts,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        begin
            if ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(0, 99) < send_idle_pct);
            end
            in_valid   <= 1'b1;
            action     <= act;
            time_stamp <= ts;
            red        <= r;
            green      <= g;
            blue       <= b;
            @(negedge clk);
            while (in_stall)
                @(negedge clk);
            @(posedge clk);
        end
    endtask

    // hold the input until every predicted beat has been seen
    task automatic wait_quiet();
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (beats_due != 0)
                @(negedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic send_pixel();
        begin
            send_item(ACT_PIXEL, $urandom, pick_color(), pick_color(), pick_color());
        end
    endtask

    // new register values, then a run of pixels; open_frame starts a frame first
    task automatic run_phase(input int s_pct, input int r_pct, input int npix,
                             input bit open_frame);
        begin
            wait_quiet();
            send_idle_pct  = s_pct;
            recv_stall_pct = r_pct;
            reg_write(REG_BRIGHTNESS, 32'($urandom_range(0, 255)));
            reg_write(REG_SSRC, $urandom);
            reg_write(REG_PAYLOAD, 32'($urandom_range(0, 127)));
            if (open_frame)
                send_item(ACT_START, $urandom, pick_color(), pick_color(), pick_color());
            for (int i = 0; i < npix; i++)
            begin
                send_pixel();
                if (open_frame && i == npix / 2)
                    wait_quiet();
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 25;
        recv_stall_pct = 57;

        // defaults after reset; stray pixel, extremes, restart of an open frame
        send_item(ACT_PIXEL, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(ACT_START, 32'h0000_0000, 8'h00, 8'h00, 8'h00);
        send_item(ACT_PIXEL, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF);
        send_item(ACT_PIXEL, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00);
        send_item(ACT_PIXEL, 32'h0000_0000, 8'hAA, 8'h55, 8'h01);
        send_item(ACT_START, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(ACT_PIXEL, 32'h1234_5678, 8'h80, 8'h7F, 8'hFE);

        wait_quiet();
        reg_write(REG_BRIGHTNESS, 32'd0);
        reg_write(REG_SSRC, 32'hFFFF_FFFF);
        reg_write(REG_PAYLOAD, 32'd127);
        send_item(ACT_START, 32'h1234_5678, 8'h00, 8'h00, 8'h00);
        send_item(ACT_PIXEL, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF);
        send_item(ACT_PIXEL, 32'h0000_0000, 8'h01, 8'h80, 8'hFE);

        wait_quiet();
        reg_write(REG_BRIGHTNESS, 32'd255);
        reg_write(REG_SSRC, 32'd0);
        reg_write(REG_PAYLOAD, 32'd0);
        send_item(ACT_START, 32'hA5A5_A5A5, 8'h00, 8'h00, 8'h00);
        send_item(ACT_PIXEL, 32'h5A5A_5A5A, 8'hFF, 8'h80, 8'h01);
        send_item(ACT_PIXEL, 32'h0000_0000, 8'h00, 8'hFF, 8'h7F);

        wait_quiet();
        reg_write(REG_BRIGHTNESS, 32'd1);
        reg_write(REG_SSRC, 32'h5A5A_5A5A);
        reg_write(REG_PAYLOAD, 32'd96);
        send_item(ACT_START, 32'h0001_0000, 8'h00, 8'h00, 8'h00);
        send_item(ACT_PIXEL, 32'h0000_0000, 8'hFF, 8'hFE, 8'h00);
        send_item(ACT_PIXEL, 32'h0000_0000, 8'h80, 8'h01, 8'hFF);

        // one full frame spread over the three idle patterns
        run_phase(25, 57, PIX_TOTAL / 3, 1'b1);
        run_phase(57, 25, PIX_TOTAL / 3, 1'b0);
        run_phase(0, 0, PIX_TOTAL - 2 * (PIX_TOTAL / 3), 1'b0);

        // frame closed, these are dropped
        repeat (2) send_pixel();

        in_valid <= 1'b0;
        @(negedge clk);
        while (beats_due != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0 && beats_due == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
